>>> hw/rtl/sscs_pkg.sv
package sscs_pkg;

    localparam int STEP_COUNT = 6;
    localparam int STEP_W     = 3;
    localparam int GATE_W     = 6;
    localparam int TIMER_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // gate bits
    localparam logic [GATE_W-1:0] G_UH  = 6'h01;
    localparam logic [GATE_W-1:0] G_UL  = 6'h02;
    localparam logic [GATE_W-1:0] G_VH  = 6'h04;
    localparam logic [GATE_W-1:0] G_VL  = 6'h08;
    localparam logic [GATE_W-1:0] G_WH  = 6'h10;
    localparam logic [GATE_W-1:0] G_WL  = 6'h20;
    localparam logic [GATE_W-1:0] G_OFF = 6'h00;

    localparam logic [STEP_W-1:0] STEP_LAST = 3'(STEP_COUNT - 1);

    typedef enum logic [1:0] {
        CMD_START        = 2'd0,
        CMD_PERIOD_START = 2'd1,
        CMD_COMPARE      = 2'd2,
        CMD_STOP         = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION_FORWARD = 1'd0,
        CFG_STEP_INTERVAL     = 1'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [GATE_W-1:0] gate_pattern;
        logic [STEP_W-1:0] active_step;
    } result_t;

    // on-time pattern: driven high side plus held low side
    function automatic logic [GATE_W-1:0] on_pattern_of(input logic [STEP_W-1:0] step);
        logic [GATE_W-1:0] g;
        case (step)
            3'd0:    g = G_UH | G_VL;
            3'd1:    g = G_UH | G_WL;
            3'd2:    g = G_VH | G_WL;
            3'd3:    g = G_VH | G_UL;
            3'd4:    g = G_WH | G_UL;
            3'd5:    g = G_WH | G_VL;
            default: g = G_OFF;
        endcase
        return g;
    endfunction

    // off-time pattern: low side only
    function automatic logic [GATE_W-1:0] off_pattern_of(input logic [STEP_W-1:0] step);
        logic [GATE_W-1:0] g;
        case (step)
            3'd0:    g = G_VL;
            3'd1:    g = G_WL;
            3'd2:    g = G_WL;
            3'd3:    g = G_UL;
            3'd4:    g = G_UL;
            3'd5:    g = G_VL;
            default: g = G_OFF;
        endcase
        return g;
    endfunction

endpackage

>>> hw/rtl/six_step_commutation_sequencer.sv
// six-step commutation sequencer, high-side pwm with the low side held on
//
// input channel (s_valid/s_ready): one timer event word per handshake,
//   s_command picks start, pwm period start, compare match or stop, and
//   s_timer_now carries the free-running timer count at that event
// result channel (m_valid/m_ready): one word per input word, the gate
//   pattern to drive and the commutation step latched after the event
// config port: cfg_wr_en writes cfg_wdata into register cfg_index
//   (0 direction_forward, 1 step_interval); the user writes only while the
//   block is idle, which the block itself does not enforce
// throughput: one word per cycle while s_ready is high; all state updates
//   in the accept cycle through one window compare and one 32-bit add
// stall: a two-entry output (result register plus skid register) lets one
//   more word in while a result waits; s_ready drops only when both are full
// reset: synchronous active-low aresetn clears step, window and pattern
//   state, empties the output, sets direction forward and interval to 160
module six_step_commutation_sequencer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_timer_now,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_gate_pattern,
    output logic [2:0]  m_active_step,

    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    // configuration registers
    logic        direction_forward_reg;
    logic [31:0] step_interval_reg;

    // sequencer state
    logic [2:0]  current_step_reg,  current_step_next;
    logic [2:0]  pending_step_reg,  pending_step_next;
    logic [31:0] window_start_reg,  window_start_next;
    logic [31:0] window_end_reg,    window_end_next;
    logic [5:0]  on_pattern_reg,    on_pattern_next;
    logic [5:0]  off_pattern_reg,   off_pattern_next;

    // output buffering
    logic                  out_valid_reg;
    sscs_pkg::result_t     out_data_reg;
    logic                  skid_valid_reg;
    sscs_pkg::result_t     skid_data_reg;

    sscs_pkg::result_t     result_next;
    sscs_pkg::cmd_t        cmd;

    logic        accept;
    logic        take;
    logic [31:0] now_offset;
    logic [31:0] window_len;
    logic        in_window;
    logic [2:0]  pending_mod;
    logic [2:0]  pending_stepped;
    logic [5:0]  gates;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign take    = out_valid_reg && m_ready;

    assign m_valid        = out_valid_reg;
    assign m_gate_pattern = out_data_reg.gate_pattern;
    assign m_active_step  = out_data_reg.active_step;

    assign cmd = sscs_pkg::cmd_t'(s_command);

    // window test with unsigned wrap: [start, end)
    assign now_offset = s_timer_now - window_start_reg;
    assign window_len = window_end_reg - window_start_reg;
    assign in_window  = now_offset < window_len;

    // pending step is kept below the step count; fold just in case
    assign pending_mod = (pending_step_reg >= 3'(sscs_pkg::STEP_COUNT))
                       ? pending_step_reg - 3'(sscs_pkg::STEP_COUNT)
                       : pending_step_reg;

    always_comb begin
        if (direction_forward_reg) begin
            pending_stepped = (pending_mod == sscs_pkg::STEP_LAST) ? 3'd0 : pending_mod + 3'd1;
        end else begin
            pending_stepped = (pending_mod == 3'd0) ? sscs_pkg::STEP_LAST : pending_mod - 3'd1;
        end
    end

    // event decode and next state
    always_comb begin
        current_step_next = current_step_reg;
        pending_step_next = pending_step_reg;
        window_start_next = window_start_reg;
        window_end_next   = window_end_reg;
        on_pattern_next   = on_pattern_reg;
        off_pattern_next  = off_pattern_reg;
        gates             = sscs_pkg::G_OFF;
        case (cmd)
            sscs_pkg::CMD_START: begin
                current_step_next = 3'd0;
                pending_step_next = 3'd0;
                window_start_next = s_timer_now;
                window_end_next   = s_timer_now + step_interval_reg;
                on_pattern_next   = sscs_pkg::G_OFF;
                off_pattern_next  = sscs_pkg::G_OFF;
            end
            sscs_pkg::CMD_PERIOD_START: begin
                gates = on_pattern_reg;
                // timer left the window: advance step and slide window
                if (!in_window) begin
                    pending_step_next = pending_stepped;
                    window_start_next = window_end_reg;
                    window_end_next   = window_end_reg + step_interval_reg;
                end
            end
            sscs_pkg::CMD_COMPARE: begin
                gates             = off_pattern_reg;
                current_step_next = pending_mod;
                on_pattern_next   = sscs_pkg::on_pattern_of(pending_mod);
                off_pattern_next  = sscs_pkg::off_pattern_of(pending_mod);
            end
            default: begin
                gates = sscs_pkg::G_OFF;
            end
        endcase
        result_next.gate_pattern = gates;
        result_next.active_step  = current_step_next;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_forward_reg <= 1'b1;
            step_interval_reg     <= 32'd160;
        end else if (cfg_wr_en) begin
            case (sscs_pkg::cfg_reg_t'(cfg_index))
                sscs_pkg::CFG_DIRECTION_FORWARD: direction_forward_reg <= cfg_wdata[0];
                sscs_pkg::CFG_STEP_INTERVAL:     step_interval_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // sequencer state update on each accepted event
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_step_reg <= 3'd0;
            pending_step_reg <= 3'd0;
            window_start_reg <= 32'd0;
            window_end_reg   <= 32'd0;
            on_pattern_reg   <= sscs_pkg::G_OFF;
            off_pattern_reg  <= sscs_pkg::G_OFF;
        end else if (accept) begin
            current_step_reg <= current_step_next;
            pending_step_reg <= pending_step_next;
            window_start_reg <= window_start_next;
            window_end_reg   <= window_end_next;
            on_pattern_reg   <= on_pattern_next;
            off_pattern_reg  <= off_pattern_next;
        end
    end

    // output register and skid: valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            if (out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // output register and skid: payload
    always_ff @(posedge aclk) begin
        if (take) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (accept) begin
                out_data_reg <= result_next;
            end
        end else if (accept) begin
            if (out_valid_reg) begin
                skid_data_reg <= result_next;
            end else begin
                out_data_reg <= result_next;
            end
        end
    end

endmodule

>>> tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // run limits
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no word moving on either channel
    localparam int HOLD_CYCLES    = 120;   // long receiver hold-off for the backpressure test
    localparam int REPORT_MAX     = 10;    // mismatches printed before we only count

    // dut ports
    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [31:0] s_timer_now;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_gate_pattern;
    logic [2:0]  m_active_step;
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_wdata;

    // commutation predictor: our own copy of registers and state
    logic        mdl_forward;
    logic [31:0] mdl_interval;
    logic [2:0]  cur_step;
    logic [2:0]  pend_step;
    logic [31:0] win_lo;
    logic [31:0] win_hi;
    logic [5:0]  gates_on;
    logic [5:0]  gates_off;

    // per-step on-time and off-time gate tables
    logic [5:0]  on_gates  [0:sscs_pkg::STEP_COUNT-1];
    logic [5:0]  off_gates [0:sscs_pkg::STEP_COUNT-1];

    // expected gate words, oldest first
    sscs_pkg::result_t gate_expect_q [$];
    sscs_pkg::result_t want;

    // stimulus control shared with the receiver process
    bit          bursts_on;
    bit          hold_request;

    // bookkeeping
    int          failures;
    int          results_seen;
    int          step_advances;
    int          cmd_count [4];
    int          quiet_cycles;

    six_step_commutation_sequencer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_timer_now    (s_timer_now),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_gate_pattern (m_gate_pattern),
        .m_active_step  (m_active_step),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // predict the gate word for one accepted event and queue it
    task automatic predict_gates(input sscs_pkg::cmd_t cmd, input logic [31:0] now);
        sscs_pkg::result_t r;
        logic [2:0]        p;
        r.gate_pattern = sscs_pkg::G_OFF;
        cmd_count[int'(cmd)]++;
        case (cmd)
            sscs_pkg::CMD_START: begin
                // restart at step 0 with a fresh window from this count
                cur_step  = '0;
                pend_step = '0;
                win_lo    = now;
                win_hi    = now + mdl_interval;
                gates_on  = sscs_pkg::G_OFF;
                gates_off = sscs_pkg::G_OFF;
            end
            sscs_pkg::CMD_PERIOD_START: begin
                r.gate_pattern = gates_on;
                // window test with 32-bit wrap, an empty window never holds
                if (!((now - win_lo) < (win_hi - win_lo))) begin
                    p = 3'(pend_step % sscs_pkg::STEP_COUNT);
                    if (mdl_forward) begin
                        pend_step = (p == sscs_pkg::STEP_LAST) ? 3'd0 : p + 3'd1;
                    end else begin
                        pend_step = (p == 3'd0) ? sscs_pkg::STEP_LAST : p - 3'd1;
                    end
                    win_lo = win_hi;
                    win_hi = win_hi + mdl_interval;
                    step_advances++;
                end
            end
            sscs_pkg::CMD_COMPARE: begin
                r.gate_pattern = gates_off;
                cur_step  = 3'(pend_step % sscs_pkg::STEP_COUNT);
                gates_on  = on_gates[cur_step];
                gates_off = off_gates[cur_step];
            end
            default: begin
                // stop: gates off, nothing else moves
            end
        endcase
        r.active_step = cur_step;
        gate_expect_q.push_back(r);
    endtask

    // offer one event word, hold it until accepted, then predict
    task automatic send_event(input sscs_pkg::cmd_t cmd, input logic [31:0] now);
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_command   = cmd;
        s_timer_now = now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_gates(cmd, now);
        @(negedge aclk);
    endtask

    // stop offering and wait for every expected word, then settle
    task automatic wait_idle();
        s_valid = 1'b0;
        while (gate_expect_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
    endtask

    // one register write, called at a falling edge while idle
    task automatic write_reg(input sscs_pkg::cfg_reg_t idx, input logic [31:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            sscs_pkg::CFG_DIRECTION_FORWARD: mdl_forward  = data[0];
            default:                         mdl_interval = data;
        endcase
    endtask

    task automatic set_mode(input logic fwd, input logic [31:0] interval);
        wait_idle();
        write_reg(sscs_pkg::CFG_DIRECTION_FORWARD, {31'd0, fwd});
        write_reg(sscs_pkg::CFG_STEP_INTERVAL, interval);
    endtask

    // events straight out of reset act on the cleared state,
    // the empty window [0,0) makes the first period start advance
    task automatic test_before_start();
        send_event(sscs_pkg::CMD_PERIOD_START, 32'h0000_0000);
        send_event(sscs_pkg::CMD_COMPARE,      32'hffff_ffff);
        send_event(sscs_pkg::CMD_PERIOD_START, 32'hffff_ffff);
        send_event(sscs_pkg::CMD_STOP,         32'h1234_5678);
        send_event(sscs_pkg::CMD_COMPARE,      32'h0000_0005);
    endtask

    // start just below the wrap so the window straddles zero
    task automatic test_window_wrap();
        set_mode(1'b1, 32'd160);
        send_event(sscs_pkg::CMD_START,        32'hffff_ffb0);
        send_event(sscs_pkg::CMD_PERIOD_START, 32'hffff_ffb0);
        send_event(sscs_pkg::CMD_PERIOD_START, 32'h0000_004f);
        send_event(sscs_pkg::CMD_PERIOD_START, 32'h0000_0050);
        send_event(sscs_pkg::CMD_COMPARE,      32'h0000_0051);
        send_event(sscs_pkg::CMD_PERIOD_START, 32'h0000_0050);
        send_event(sscs_pkg::CMD_COMPARE,      32'h0000_0060);
        send_event(sscs_pkg::CMD_STOP,         32'h0000_0070);
    endtask

    // backward stepping with the widest interval, last count falls out
    task automatic test_backward_max_interval();
        set_mode(1'b0, 32'hffff_ffff);
        send_event(sscs_pkg::CMD_START,        32'h0000_0000);
        send_event(sscs_pkg::CMD_PERIOD_START, 32'hffff_fffe);
        send_event(sscs_pkg::CMD_PERIOD_START, 32'hffff_ffff);
        send_event(sscs_pkg::CMD_COMPARE,      32'h8000_0000);
    endtask

    // zero interval: empty window, every period start advances
    task automatic test_zero_interval();
        set_mode(1'b0, 32'd0);
        send_event(sscs_pkg::CMD_START,        32'h8000_0000);
        send_event(sscs_pkg::CMD_PERIOD_START, 32'h8000_0000);
        send_event(sscs_pkg::CMD_PERIOD_START, 32'h8000_0000);
        send_event(sscs_pkg::CMD_COMPARE,      32'h8000_0001);
    endtask

    // receiver holds off while the sender keeps offering, so the two-word
    // output fills up and s_ready has to drop
    task automatic test_output_backpressure();
        int i;
        set_mode(1'b1, 32'd40);
        bursts_on    = 1'b0;
        hold_request = 1'b1;
        send_event(sscs_pkg::CMD_START, $urandom);
        for (i = 0; i < 23; i++) begin
            send_event((i % 2 == 0) ? sscs_pkg::CMD_PERIOD_START : sscs_pkg::CMD_COMPARE,
                       32'(i * 13));
        end
        wait_idle();
        bursts_on = 1'b1;
    endtask

    // mostly well-formed period start / compare pairs with a timer moving
    // at a pace that crosses a window every few pwm periods, plus noise,
    // lone events and stop/restart breaks
    task automatic run_commutation(input int n_items);
        int          i;
        int          r;
        logic [31:0] t;
        logic [31:0] tick_max;
        tick_max = (mdl_interval < 32'd3) ? 32'd3 : mdl_interval / 3;
        t = $urandom;
        send_event(sscs_pkg::CMD_START, t);
        i = 1;
        while (i < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_event(sscs_pkg::cmd_t'($urandom_range(0, 3)), $urandom);
                i++;
            end else if (r < 8) begin
                t = $urandom;
                send_event(sscs_pkg::CMD_STOP, t);
                send_event(sscs_pkg::CMD_START, t);
                i += 2;
            end else if (r < 16) begin
                t = t + $urandom_range(0, tick_max);
                send_event(($urandom_range(0, 1) == 1) ? sscs_pkg::CMD_PERIOD_START
                                                       : sscs_pkg::CMD_COMPARE, t);
                i++;
            end else begin
                t = t + $urandom_range(0, tick_max);
                send_event(sscs_pkg::CMD_PERIOD_START, t);
                send_event(sscs_pkg::CMD_COMPARE, t + $urandom_range(0, tick_max / 2));
                i += 2;
            end
        end
    endtask

    // several register settings, extremes among them; last phase runs flat out
    task automatic test_random_commutation();
        set_mode(1'b1, 32'd160);
        run_commutation(330);
        set_mode(1'b0, 32'd1);
        run_commutation(330);
        bursts_on = 1'b0;
        set_mode(1'b1, 32'hffff_ffff);
        run_commutation(330);
        bursts_on = 1'b1;
        set_mode(1'b0, $urandom_range(2, 5000));
        run_commutation(330);
        bursts_on = 1'b0;
        set_mode(1'($urandom_range(0, 1)), $urandom | 32'd1);
        run_commutation(330);
    endtask

    // receiver: random stall bursts, or one long hold when asked
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_request = 1'b0;
            end else if (bursts_on && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // result checker: every accepted word against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (gate_expect_q.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX) begin
                    $display("[%0t] unexpected word: gates %02h step %0d",
                             $realtime, m_gate_pattern, m_active_step);
                end
            end else begin
                want = gate_expect_q.pop_front();
                if (want.gate_pattern !== m_gate_pattern ||
                    want.active_step !== m_active_step) begin
                    failures++;
                    if (failures <= REPORT_MAX) begin
                        $display({"[%0t] mismatch: gates exp %02h got %02h, ",
                                  "step exp %0d got %0d"},
                                 $realtime, want.gate_pattern, m_gate_pattern,
                                 want.active_step, m_active_step);
                    end
                end
            end
        end
    end

    // watchdog: too long with nothing moving on either channel
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // main sequence
    initial begin
        // step tables: high side on plus held low side, low side only
        on_gates[0] = sscs_pkg::G_UH | sscs_pkg::G_VL;  off_gates[0] = sscs_pkg::G_VL;
        on_gates[1] = sscs_pkg::G_UH | sscs_pkg::G_WL;  off_gates[1] = sscs_pkg::G_WL;
        on_gates[2] = sscs_pkg::G_VH | sscs_pkg::G_WL;  off_gates[2] = sscs_pkg::G_WL;
        on_gates[3] = sscs_pkg::G_VH | sscs_pkg::G_UL;  off_gates[3] = sscs_pkg::G_UL;
        on_gates[4] = sscs_pkg::G_WH | sscs_pkg::G_UL;  off_gates[4] = sscs_pkg::G_UL;
        on_gates[5] = sscs_pkg::G_WH | sscs_pkg::G_VL;  off_gates[5] = sscs_pkg::G_VL;

        // predictor state after reset
        mdl_forward  = 1'b1;
        mdl_interval = 32'd160;
        cur_step     = '0;
        pend_step    = '0;
        win_lo       = '0;
        win_hi       = '0;
        gates_on     = sscs_pkg::G_OFF;
        gates_off    = sscs_pkg::G_OFF;

        failures      = 0;
        results_seen  = 0;
        step_advances = 0;
        foreach (cmd_count[i]) cmd_count[i] = 0;
        bursts_on    = 1'b1;
        hold_request = 1'b0;

        // all inputs known from time zero, reset held low until the tests begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_command   = sscs_pkg::CMD_STOP;
        s_timer_now = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = sscs_pkg::CFG_DIRECTION_FORWARD;
        cfg_wdata   = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_before_start();
        test_window_wrap();
        test_backward_max_interval();
        test_zero_interval();
        test_output_backpressure();
        test_random_commutation();

        // drain, then check that no expected word is left
        wait_idle();
        repeat (8) @(posedge aclk);
        if (gate_expect_q.size() != 0) begin
            failures++;
            $display("%0d expected words never arrived", gate_expect_q.size());
        end

        $display("covered %0d start, %0d period start, %0d compare, %0d stop words; %0d results",
                 cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], results_seen);
        $display({"%0d step advances, both directions, intervals 0 to max, ",
                  "wrapped windows, long stall"}, step_advances);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
